[rtl/spoe_pkg.sv]
// ----------------------------------------------------------------------------
// spoe_pkg: shared types and constants
// Transaction payloads, function codes and screen limits for the sprite piece
// to attribute entry block.
// ----------------------------------------------------------------------------
package spoe_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 60;
  localparam int unsigned OAM_SLOTS_DEF     = 128;
  localparam int unsigned SLOT_W            = 7;
  localparam int unsigned WIDX_W            = 7;

  localparam int signed SCREEN_W = 240;
  localparam int signed SCREEN_H = 160;

  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_RENDER = 2'd1,
    FUNC_FRAME  = 2'd2
  } func_e;

  typedef struct packed {
    logic [1:0]         func;
    logic [5:0]         table_index;
    logic [31:0]        table_word;
    logic signed [7:0]  x_offset;
    logic signed [7:0]  y_offset;
    logic [7:0]         shape_info;
    logic [7:0]         tile_low;
    logic [7:0]         tile_high;
    logic signed [15:0] base_x;
    logic signed [15:0] base_y;
    logic [31:0]        flags;
    logic [15:0]        extra;
  } in_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [31:0]       attr_word;
    logic [15:0]       attr_two;
  } out_t;

  typedef struct packed {
    logic        visible;
    logic [31:0] attr_word;
    logic [15:0] attr_two;
  } build_t;

  // Table word index from the mode bits and the shape/size bits.
  function automatic logic [WIDX_W-1:0] word_index(logic [31:0] flags, logic [7:0] shape);
    logic [WIDX_W-1:0] base;
    if (flags[9:8] != 2'b00) begin
      base = (flags[9:8] == 2'b01) ? WIDX_W'(0) : WIDX_W'(48);
    end else begin
      base = WIDX_W'({flags[29:28], 3'b000}) + WIDX_W'({flags[29:28], 2'b00});
    end
    return base + WIDX_W'(shape[7:4]);
  endfunction

endpackage

[rtl/spoe_build.sv]
// ----------------------------------------------------------------------------
// spoe_build: piece placement, clipping and attribute packing
// Applies the offset flips, places the piece against its anchor, clips it
// to the screen and forms both attribute words.
// ----------------------------------------------------------------------------
module spoe_build (
  input  spoe_pkg::in_t    item_i,
  input  logic [31:0]      entry_i,
  output spoe_pkg::build_t build_o
);

  logic               affine;
  logic signed [7:0]  xo;
  logic signed [7:0]  yo;
  logic signed [17:0] x;
  logic signed [17:0] y;
  logic signed [17:0] x_end;
  logic signed [17:0] y_end;
  logic [31:0]        aw_base;
  logic [15:0]        tile_sum;

  assign affine = (item_i.flags[9:8] != 2'b00);

  // 8-bit negation leaves -128 at -128
  assign xo = (!affine && item_i.flags[28]) ? -item_i.x_offset : item_i.x_offset;
  assign yo = (!affine && item_i.flags[29]) ? -item_i.y_offset : item_i.y_offset;

  assign y = 18'(yo) + 18'(item_i.base_y) - $signed({10'b0, entry_i[15:8]});
  assign x = 18'(xo) + 18'(item_i.base_x) - $signed({10'b0, entry_i[7:0]});
  assign y_end = y + $signed({10'b0, entry_i[31:24]});
  assign x_end = x + $signed({10'b0, entry_i[23:16]});

  assign aw_base = 32'(y[7:0]) | (32'(x[8:0]) << 16) | (32'(item_i.shape_info[7:6]) << 14);

  always_comb begin
    tile_sum = 16'(item_i.tile_low) + item_i.extra;
    if (item_i.shape_info[0]) begin
      tile_sum = tile_sum & 16'h0FFF;
    end
    build_o.visible   = (y < 18'(spoe_pkg::SCREEN_H)) && (y_end > 18'sd0) &&
                        (x < 18'(spoe_pkg::SCREEN_W)) && (x_end > 18'sd0);
    build_o.attr_word = (aw_base | item_i.flags) ^ (32'(item_i.shape_info[5:2]) << 28);
    build_o.attr_two  = tile_sum + {item_i.tile_high, 8'h00};
  end

endmodule

[rtl/sprite_piece_to_oam_entry.sv]
// ----------------------------------------------------------------------------
// sprite_piece_to_oam_entry: sprite piece to attribute entry
// Loads the anchor/size table, places and clips pieces and emits packed
// attribute entries at consecutive slots.
// ----------------------------------------------------------------------------
// One transaction is taken every cycle unless the input stalls. A transaction
// is registered together with its size table read (the table has one write
// port and one registered read port: a load writes it, a render reads it,
// both in the accept cycle), then clipped and packed into the output
// register, from which the sink takes the result. Loads, frame starts and
// clipped pieces produce no result. The only backpressure is the output
// register: input stalls only while a result is held, the sink stalls and
// the input register holds a transaction.
module sprite_piece_to_oam_entry #(
  parameter int unsigned TABLE_ENTRIES = spoe_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned OAM_SLOTS     = spoe_pkg::OAM_SLOTS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  spoe_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output spoe_pkg::out_t out_data_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W = $clog2(OAM_SLOTS + 1);

  logic [31:0]            table_mem [TABLE_ENTRIES];

  logic                   in_acc;
  logic                   advance;
  logic [spoe_pkg::WIDX_W-1:0] widx;
  logic                   widx_ok;
  logic                   load_ok;
  logic [IDX_W-1:0]       rd_idx;

  logic                   s1_valid_q;
  spoe_pkg::in_t          s1_item_q;
  logic                   s1_idx_ok_q;
  logic [31:0]            s1_entry_q;

  spoe_pkg::build_t       build;
  logic                   full;
  logic                   emit;

  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   out_valid_q;
  spoe_pkg::out_t         out_q;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_acc     = in_valid_i && !in_stall_o;

  assign widx    = spoe_pkg::word_index(in_data_i.flags, in_data_i.shape_info);
  assign widx_ok = (32'(widx) < TABLE_ENTRIES);
  assign load_ok = (32'(in_data_i.table_index) < TABLE_ENTRIES);
  assign rd_idx  = widx_ok ? widx[IDX_W-1:0] : '0;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      if (in_data_i.func == spoe_pkg::FUNC_LOAD && load_ok) begin
        table_mem[in_data_i.table_index[IDX_W-1:0]] <= in_data_i.table_word;
      end
      s1_entry_q <= table_mem[rd_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_item_q   <= in_data_i;
      s1_idx_ok_q <= widx_ok;
    end
  end

  spoe_build u_build (
    .item_i  (s1_item_q),
    .entry_i (s1_entry_q),
    .build_o (build)
  );

  assign full = (cnt_q >= CNT_W'(OAM_SLOTS));
  assign emit = s1_valid_q && (s1_item_q.func == spoe_pkg::FUNC_RENDER) &&
                s1_idx_ok_q && !full && build.visible;

  always_comb begin
    cnt_d = cnt_q;
    if (s1_valid_q && advance) begin
      if (s1_item_q.func == spoe_pkg::FUNC_FRAME) begin
        cnt_d = '0;
      end else if (emit) begin
        cnt_d = cnt_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (advance) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_q.slot      <= spoe_pkg::SLOT_W'(cnt_q);
      out_q.attr_word <= build.attr_word;
      out_q.attr_two  <= build.attr_two;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[rtl/spoe_checker.sv]
// ----------------------------------------------------------------------------
// spoe_checker: port-level checks
// Watches the top level's ports for handshake and backpressure behavior.
// ----------------------------------------------------------------------------
module spoe_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input spoe_pkg::out_t out_data_o
);

  // input only backs up behind a held result
  a_stall_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled while output free");

  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result shown during reset");

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result dropped");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind sprite_piece_to_oam_entry spoe_checker u_spoe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
